/* design/alarm_priority_top_n_table_assert.svh */
// Assertion macros for the alarm priority table.
`ifndef ALARM_PRIORITY_TOP_N_TABLE_ASSERT_SVH
`define ALARM_PRIORITY_TOP_N_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define APT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define APT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define APT_ASSERT(lbl, prop, msg)
`define APT_NEVER(lbl, expr, msg)
`endif
`endif

/* design/apt_pkg.sv */
// Shared types, codes and helpers for the alarm priority table.
`timescale 1ns / 1ps
package apt_pkg;

  localparam int ENTRIES_DEF  = 8;
  localparam int TIME_MAX_DEF = 63;
  localparam int LEVEL_WEIGHT = 100;

  localparam int CMD_W    = 2;
  localparam int OBJ_W    = 16;
  localparam int LVL_W    = 3;
  localparam int TIME_W   = 10;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int PRIO_W   = 12;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_KEPT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RAISED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_OOR = 3'd6;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd7;

  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    prio_t             prio;
  } rank_ent_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
  } sort_cmd_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    prio_t             prio;
  } prio_wr_t;

  function automatic prio_t prio_calc(input logic [LVL_W-1:0] lvl,
                                      input logic [TIME_W-1:0] tim,
                                      input int tmax);
    int p;
    p = LEVEL_WEIGHT * int'(lvl) + tmax - int'(tim);
    return PRIO_W'(p);
  endfunction

endpackage

/* design/apt_sort.sv */
// Rank order store and selection sort engine with one shared comparator.
`timescale 1ns / 1ps
module apt_sort #(
  parameter int ENTRIES = apt_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apt_pkg::sort_cmd_t         sort_cmd,
  input  apt_pkg::prio_wr_t          prio_wr,
  input  logic [apt_pkg::SLOT_W-1:0] rank_addr,
  output apt_pkg::rank_ent_t         rank_q,
  output logic                       busy
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = apt_pkg::COUNT_W;
  localparam int SL_W  = apt_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;

  apt_pkg::prio_t     prio_mem [ENTRIES];
  apt_pkg::rank_ent_t rank_mem [ENTRIES];

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   jd_r, jd_nxt;
  logic [CNT_W-1:0]   widx_r, widx_nxt;
  logic               wpend_r, wpend_nxt;
  apt_pkg::rank_ent_t cur_r, cur_nxt;
  apt_pkg::prio_t     prio_q_r;
  apt_pkg::rank_ent_t rank_q_r;

  logic               rk_we;
  logic [IDX_W-1:0]   rk_waddr;
  apt_pkg::rank_ent_t rk_wdata;
  logic [IDX_W-1:0]   rk_raddr;

  assign busy   = (state_r != S_IDLE);
  assign rank_q = rank_q_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    jd_nxt    = jd_r;
    widx_nxt  = widx_r;
    wpend_nxt = 1'b0;
    cur_nxt   = cur_r;
    rk_we     = 1'b0;
    rk_waddr  = widx_r[IDX_W-1:0];
    rk_wdata  = '{slot: widx_r[SL_W-1:0], prio: prio_q_r};
    rk_raddr  = rank_addr[IDX_W-1:0];
    if (wpend_r) begin
      rk_we = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (sort_cmd.start) begin
          n_nxt     = sort_cmd.count;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (j_r < n_r) begin
          wpend_nxt = 1'b1;
          widx_nxt  = j_r;
          j_nxt     = j_r + CNT_W'(1);
        end else begin
          state_nxt = (n_r > CNT_W'(1)) ? S_LOAD : S_IDLE;
        end
      end
      S_LOAD: begin
        rk_raddr  = i_r[IDX_W-1:0];
        j_nxt     = i_r + CNT_W'(1);
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cur_nxt   = rank_q_r;
        rk_raddr  = j_r[IDX_W-1:0];
        jd_nxt    = j_r;
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rk_raddr = j_r[IDX_W-1:0];
        if ($signed(cur_r.prio) < $signed(rank_q_r.prio)) begin
          rk_we    = 1'b1;
          rk_waddr = jd_r[IDX_W-1:0];
          rk_wdata = cur_r;
          cur_nxt  = rank_q_r;
        end
        if (j_r < n_r) begin
          jd_nxt = j_r;
          j_nxt  = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        rk_we     = 1'b1;
        rk_waddr  = i_r[IDX_W-1:0];
        rk_wdata  = cur_r;
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = ((i_r + CNT_W'(2)) < n_r) ? S_LOAD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    jd_r   <= jd_nxt;
    widx_r <= widx_nxt;
    cur_r  <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (prio_wr.we) begin
      prio_mem[prio_wr.slot[IDX_W-1:0]] <= prio_wr.prio;
    end
    prio_q_r <= prio_mem[j_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rank_mem[rk_waddr] <= rk_wdata;
    end
    rank_q_r <= rank_mem[rk_raddr];
  end

endmodule

/* design/alarm_priority_top_n_table.sv */
// Top level of the bounded top-N alarm priority table.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    cmd, object_id, alarm_level, time, rank
//   out_     output     out_valid / out_ready  status, slot, count, read fields
//
// An add passes accept, search and result (fewer search steps on a match), with a read and
// check of the last rank when the table is full, and on any change a rebuild of the n
// entries after it, set by the single compare unit stepping the rank store.
// A read at a valid rank adds rank, slot and data reads; other reads, clear and unassigned
// commands go straight to the result. No command is accepted until the last has its result.
// Reset empties the table; no clearing pass runs.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`include "alarm_priority_top_n_table_assert.svh"
module alarm_priority_top_n_table #(
  parameter int ENTRIES  = apt_pkg::ENTRIES_DEF,
  parameter int TIME_MAX = apt_pkg::TIME_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [apt_pkg::OBJ_W-1:0]    in_object_id,
  input  logic [apt_pkg::LVL_W-1:0]    in_alarm_level,
  input  logic [apt_pkg::TIME_W-1:0]   in_time_to_encounter,
  input  logic [apt_pkg::RANK_W-1:0]   in_rank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apt_pkg::STATUS_W-1:0] out_status,
  output logic [apt_pkg::SLOT_W-1:0]   out_slot,
  output logic [apt_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [apt_pkg::OBJ_W-1:0]    out_read_object,
  output logic [apt_pkg::LVL_W-1:0]    out_read_level,
  output logic [apt_pkg::TIME_W-1:0]   out_read_time
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = apt_pkg::COUNT_W;
  localparam int SL_W  = apt_pkg::SLOT_W;
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
  localparam logic [SL_W-1:0]  LAST_RANK   = SL_W'(ENTRIES - 1);

  localparam logic [3:0] T_IDLE    = 4'd0;
  localparam logic [3:0] T_SEARCH  = 4'd1;
  localparam logic [3:0] T_FULLRD  = 4'd2;
  localparam logic [3:0] T_FULLCHK = 4'd3;
  localparam logic [3:0] T_RDRANK  = 4'd4;
  localparam logic [3:0] T_RDSLOT  = 4'd5;
  localparam logic [3:0] T_RDDATA  = 4'd6;
  localparam logic [3:0] T_SORT    = 4'd7;
  localparam logic [3:0] T_DONE    = 4'd8;

  typedef struct packed {
    logic [apt_pkg::OBJ_W-1:0]  obj;
    logic [apt_pkg::LVL_W-1:0]  lvl;
    logic [apt_pkg::TIME_W-1:0] tim;
    apt_pkg::prio_t             prio;
  } slot_ent_t;

  slot_ent_t slot_mem [ENTRIES];
  slot_ent_t sq_r;

  logic [3:0]                   state_r, state_nxt;
  logic [apt_pkg::CMD_W-1:0]    cmd_r;
  logic [apt_pkg::OBJ_W-1:0]    obj_r;
  logic [apt_pkg::LVL_W-1:0]    lvl_r;
  logic [apt_pkg::TIME_W-1:0]   tim_r;
  logic [apt_pkg::RANK_W-1:0]   rank_r;
  apt_pkg::prio_t               np_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             issue_r, issue_nxt;
  logic                         chkv_r, chkv_nxt;
  logic [apt_pkg::STATUS_W-1:0] pst_r, pst_nxt;
  logic [SL_W-1:0]              pslot_r, pslot_nxt;
  logic [apt_pkg::OBJ_W-1:0]    pobj_r, pobj_nxt;
  logic [apt_pkg::LVL_W-1:0]    plvl_r, plvl_nxt;
  logic [apt_pkg::TIME_W-1:0]   ptim_r, ptim_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;
  logic [apt_pkg::STATUS_W-1:0] out_status_r;
  logic [SL_W-1:0]              out_slot_r;
  logic [CNT_W-1:0]             out_count_r;
  logic [apt_pkg::OBJ_W-1:0]    out_obj_r;
  logic [apt_pkg::LVL_W-1:0]    out_lvl_r;
  logic [apt_pkg::TIME_W-1:0]   out_tim_r;

  logic                         in_accept;
  logic                         sw_we;
  logic [SL_W-1:0]              sw_addr;
  logic [IDX_W-1:0]             sr_addr;
  logic [CNT_W-1:0]             found_idx;
  logic [SL_W-1:0]              rank_addr;
  apt_pkg::sort_cmd_t           sort_cmd;
  apt_pkg::prio_wr_t            prio_wr;
  apt_pkg::rank_ent_t           rank_q;
  logic                         srt_busy;

  apt_sort #(
    .ENTRIES (ENTRIES)
  ) u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .sort_cmd  (sort_cmd),
    .prio_wr   (prio_wr),
    .rank_addr (rank_addr),
    .rank_q    (rank_q),
    .busy      (srt_busy)
  );

  assign in_ready  = (state_r == T_IDLE);
  assign in_accept = in_valid && in_ready;
  assign found_idx = issue_r - CNT_W'(1);
  assign rank_addr = (cmd_r == apt_pkg::CMD_READ) ? rank_r : LAST_RANK;
  assign sr_addr   = (state_r == T_SEARCH) ? issue_r[IDX_W-1:0] : rank_q.slot[IDX_W-1:0];
  assign prio_wr   = '{we: sw_we, slot: sw_addr, prio: np_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    chkv_nxt       = chkv_r;
    pst_nxt        = pst_r;
    pslot_nxt      = pslot_r;
    pobj_nxt       = pobj_r;
    plvl_nxt       = plvl_r;
    ptim_nxt       = ptim_r;
    sw_we          = 1'b0;
    sw_addr        = rank_q.slot;
    sort_cmd.start = 1'b0;
    sort_cmd.count = count_r;
    out_load       = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          issue_nxt = '0;
          chkv_nxt  = 1'b0;
          pslot_nxt = '0;
          pobj_nxt  = '0;
          plvl_nxt  = '0;
          ptim_nxt  = '0;
          pst_nxt   = apt_pkg::ST_READ_OOR;
          unique case (in_cmd)
            apt_pkg::CMD_ADD: begin
              state_nxt = T_SEARCH;
            end
            apt_pkg::CMD_READ: begin
              state_nxt = ({1'b0, in_rank} < count_r) ? T_RDRANK : T_DONE;
            end
            apt_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              pst_nxt   = apt_pkg::ST_CLEARED;
              state_nxt = T_DONE;
            end
            default: begin
              state_nxt = T_DONE;
            end
          endcase
        end
      end
      T_SEARCH: begin
        priority if (chkv_r && (sq_r.obj == obj_r)) begin
          pslot_nxt = found_idx[SL_W-1:0];
          if ($signed(np_r) > $signed(sq_r.prio)) begin
            sw_we          = 1'b1;
            sw_addr        = found_idx[SL_W-1:0];
            sort_cmd.start = 1'b1;
            pst_nxt        = apt_pkg::ST_RAISED;
            state_nxt      = T_SORT;
          end else begin
            pst_nxt   = apt_pkg::ST_KEPT;
            state_nxt = T_DONE;
          end
        end else if (issue_r < count_r) begin
          issue_nxt = issue_r + CNT_W'(1);
          chkv_nxt  = 1'b1;
        end else if (count_r < ENTRIES_CNT) begin
          sw_we          = 1'b1;
          sw_addr        = count_r[SL_W-1:0];
          count_nxt      = count_r + CNT_W'(1);
          sort_cmd.start = 1'b1;
          sort_cmd.count = count_r + CNT_W'(1);
          pst_nxt        = apt_pkg::ST_INSERTED;
          pslot_nxt      = count_r[SL_W-1:0];
          state_nxt      = T_SORT;
        end else begin
          state_nxt = T_FULLRD;
        end
      end
      T_FULLRD: begin
        state_nxt = T_FULLCHK;
      end
      T_FULLCHK: begin
        if ($signed(rank_q.prio) > $signed(np_r)) begin
          pst_nxt   = apt_pkg::ST_REJECTED;
          state_nxt = T_DONE;
        end else begin
          sw_we          = 1'b1;
          sort_cmd.start = 1'b1;
          pst_nxt        = apt_pkg::ST_REPLACED;
          pslot_nxt      = rank_q.slot;
          state_nxt      = T_SORT;
        end
      end
      T_RDRANK: begin
        state_nxt = T_RDSLOT;
      end
      T_RDSLOT: begin
        state_nxt = T_RDDATA;
      end
      T_RDDATA: begin
        pst_nxt   = apt_pkg::ST_READ_OK;
        pslot_nxt = rank_q.slot;
        pobj_nxt  = sq_r.obj;
        plvl_nxt  = sq_r.lvl;
        ptim_nxt  = sq_r.tim;
        state_nxt = T_DONE;
      end
      T_SORT: begin
        if (!srt_busy) begin
          state_nxt = T_DONE;
        end
      end
      T_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_cmd;
      obj_r  <= in_object_id;
      lvl_r  <= in_alarm_level;
      tim_r  <= in_time_to_encounter;
      rank_r <= in_rank;
      np_r   <= apt_pkg::prio_calc(in_alarm_level, in_time_to_encounter, TIME_MAX);
    end
    issue_r <= issue_nxt;
    chkv_r  <= chkv_nxt;
    pst_r   <= pst_nxt;
    pslot_r <= pslot_nxt;
    pobj_r  <= pobj_nxt;
    plvl_r  <= plvl_nxt;
    ptim_r  <= ptim_nxt;
    if (out_load) begin
      out_status_r <= pst_r;
      out_slot_r   <= pslot_r;
      out_count_r  <= count_r;
      out_obj_r    <= pobj_r;
      out_lvl_r    <= plvl_r;
      out_tim_r    <= ptim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sw_we) begin
      slot_mem[sw_addr[IDX_W-1:0]] <= '{obj: obj_r, lvl: lvl_r, tim: tim_r, prio: np_r};
    end
    sq_r <= slot_mem[sr_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;
  assign out_read_object = out_obj_r;
  assign out_read_level  = out_lvl_r;
  assign out_read_time   = out_tim_r;

  `APT_NEVER(a_count_range, count_r > ENTRIES_CNT, "entry count above table size")
  `APT_ASSERT(a_sort_idle, sort_cmd.start |-> !srt_busy, "rebuild started while busy")
  `APT_ASSERT(a_wr_pair, sw_we |-> (prio_wr.we && (prio_wr.slot == sw_addr)), "priority copy out of step")
  `APT_ASSERT(a_clear, (in_accept && (in_cmd == apt_pkg::CMD_CLEAR)) |=> (count_r == '0), "clear left entries")

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the alarm priority table: directed rows, then phased random traffic.
`timescale 1ns / 1ps
module tb_top;
  import apt_pkg::*;

  localparam int N_SLOTS = ENTRIES_DEF;
  localparam int T_MAX = TIME_MAX_DEF;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int PHASE_ITEMS = 250;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 150;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [OBJ_W-1:0]  obj;
    logic [LVL_W-1:0]  lvl;
    logic [TIME_W-1:0] tim;
    logic [RANK_W-1:0] rank;
  } alarm_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic [OBJ_W-1:0]    obj;
    logic [LVL_W-1:0]    lvl;
    logic [TIME_W-1:0]   tim;
  } alarm_result_t;

  typedef struct packed {
    alarm_item_t   it;
    bit            typed;
    alarm_result_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [OBJ_W-1:0]    in_object_id = '0;
  logic [LVL_W-1:0]    in_alarm_level = '0;
  logic [TIME_W-1:0]   in_time_to_encounter = '0;
  logic [RANK_W-1:0]   in_rank = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_entry_count;
  logic [OBJ_W-1:0]    out_read_object;
  logic [LVL_W-1:0]    out_read_level;
  logic [TIME_W-1:0]   out_read_time;

  alarm_priority_top_n_table u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_object_id         (in_object_id),
    .in_alarm_level       (in_alarm_level),
    .in_time_to_encounter (in_time_to_encounter),
    .in_rank              (in_rank),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_entry_count      (out_entry_count),
    .out_read_object      (out_read_object),
    .out_read_level       (out_read_level),
    .out_read_time        (out_read_time)
  );

  always #5 clk = ~clk;

  logic [OBJ_W-1:0]  tab_obj  [N_SLOTS];
  logic [LVL_W-1:0]  tab_lvl  [N_SLOTS];
  logic [TIME_W-1:0] tab_time [N_SLOTS];
  int                rank_slot [N_SLOTS];
  int                tab_count = 0;

  alarm_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_hits [8];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 25;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic int urgency(input logic [LVL_W-1:0] lvl, input logic [TIME_W-1:0] tim);
    return LEVEL_WEIGHT * int'(lvl) + T_MAX - int'(tim);
  endfunction

  function automatic int slot_urgency(input int s);
    return urgency(tab_lvl[s], tab_time[s]);
  endfunction

  function automatic void rerank();
    int best, pj, tmp;
    for (int i = 0; i < tab_count; i++) rank_slot[i] = i;
    for (int i = 0; i < tab_count; i++) begin
      best = slot_urgency(rank_slot[i]);
      for (int j = i + 1; j < tab_count; j++) begin
        pj = slot_urgency(rank_slot[j]);
        if (best < pj) begin
          tmp = rank_slot[i];
          rank_slot[i] = rank_slot[j];
          rank_slot[j] = tmp;
          best = pj;
        end
      end
    end
  endfunction

  function automatic alarm_result_t apply_alarm(input alarm_item_t it);
    alarm_result_t r;
    int np, s;
    bit found, take;
    r = '0;
    r.status = ST_READ_OOR;
    found = 1'b0;
    take = 1'b1;
    s = 0;
    case (it.cmd)
      CMD_ADD: begin
        np = urgency(it.lvl, it.tim);
        for (int i = 0; i < tab_count; i++) begin
          if (!found && tab_obj[i] == it.obj) begin
            found = 1'b1;
            r.slot = SLOT_W'(i);
            if (np > slot_urgency(i)) begin
              tab_lvl[i] = it.lvl;
              tab_time[i] = it.tim;
              rerank();
              r.status = ST_RAISED;
            end else begin
              r.status = ST_KEPT;
            end
          end
        end
        if (!found) begin
          if (tab_count < N_SLOTS) begin
            s = tab_count;
            tab_count++;
            r.status = ST_INSERTED;
          end else begin
            s = rank_slot[N_SLOTS-1];
            if (slot_urgency(s) > np) begin
              take = 1'b0;
              r.status = ST_REJECTED;
            end else begin
              r.status = ST_REPLACED;
            end
          end
          if (take) begin
            tab_obj[s] = it.obj;
            tab_lvl[s] = it.lvl;
            tab_time[s] = it.tim;
            rerank();
            r.slot = SLOT_W'(s);
          end
        end
      end
      CMD_READ: begin
        if (int'(it.rank) < tab_count) begin
          s = rank_slot[int'(it.rank)];
          r.status = ST_READ_OK;
          r.slot = SLOT_W'(s);
          r.obj = tab_obj[s];
          r.lvl = tab_lvl[s];
          r.tim = tab_time[s];
        end
      end
      CMD_CLEAR: begin
        tab_count = 0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    r.count = COUNT_W'(tab_count);
    return r;
  endfunction

  function automatic alarm_item_t mk(input logic [CMD_W-1:0] c, input int o, input int l,
                                     input int t, input int rk);
    return '{c, OBJ_W'(o), LVL_W'(l), TIME_W'(t), RANK_W'(rk)};
  endfunction

  function automatic alarm_result_t outcome(input logic [STATUS_W-1:0] st, input int sl,
                                            input int cnt, input int o, input int l,
                                            input int t);
    return '{st, SLOT_W'(sl), COUNT_W'(cnt), OBJ_W'(o), LVL_W'(l), TIME_W'(t)};
  endfunction

  function automatic alarm_item_t rand_item();
    alarm_item_t it;
    int pick;
    it.cmd = CMD_ADD;
    it.obj = OBJ_W'($urandom);
    it.lvl = LVL_W'($urandom);
    it.tim = TIME_W'($urandom);
    it.rank = RANK_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 2) it.cmd = CMD_CLEAR;
    else if (pick < 4) it.cmd = CMD_NONE;
    else if (pick < 34) it.cmd = CMD_READ;
    if ($urandom_range(99) < 85) it.obj = OBJ_W'($urandom_range(11) * 16'h1111);
    if ($urandom_range(1) == 0) it.tim = TIME_W'($urandom_range(66, 58));
    if ($urandom_range(99) < 80) it.rank = RANK_W'($urandom_range(9));
    return it;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic offer(input alarm_item_t it, input bit typed, input alarm_result_t want);
    alarm_result_t model_res;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_object_id <= it.obj;
    in_alarm_level <= it.lvl;
    in_time_to_encounter <= it.tim;
    in_rank <= it.rank;
    do @(posedge clk); while (!in_ready);
    model_res = apply_alarm(it);
    pending_results.push_back(typed ? want : model_res);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    alarm_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_hits[out_status]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: expected no item, actual status %0d slot %0d", $time, out_status,
                 out_slot);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("slot", want.slot, out_slot);
        check_field("entry_count", want.count, out_entry_count);
        check_field("read_object", want.obj, out_read_object);
        check_field("read_level", want.lvl, out_read_level);
        check_field("read_time", want.tim, out_read_time);
      end
    end
  end

  initial begin : driver
    plan_row_t plan[$];
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1'b1, outcome(ST_READ_OOR, 0, 0, 0, 0, 0)});
    plan.push_back('{mk(CMD_NONE, 16'hFFFF, 7, 1023, 63), 1'b1,
                     outcome(ST_READ_OOR, 0, 0, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 16'hFFFF, 7, 0, 63), 1'b1, outcome(ST_INSERTED, 0, 1, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 0, 0, 1023, 0), 1'b1, outcome(ST_INSERTED, 1, 2, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 16'hFFFF, 7, 0, 0), 1'b1, outcome(ST_KEPT, 0, 2, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 0, 0, 1000, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 0, 0, 1023, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1'b1,
                     outcome(ST_READ_OK, 0, 2, 16'hFFFF, 7, 0)});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 63), 1'b1, outcome(ST_READ_OOR, 0, 2, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 16'h0001, 3, 10, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0002, 3, 10, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0004, 2, 0, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0008, 1, 500, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0010, 4, 1023, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0020, 3, 10, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0040, 0, 1023, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0080, 0, 1000, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_ADD, 16'h0100, 5, 5, 0), 1'b0, '0});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 7), 1'b0, '0});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 8), 1'b1, outcome(ST_READ_OOR, 0, 8, 0, 0, 0)});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 3), 1'b0, '0});
    plan.push_back('{mk(CMD_NONE, 16'hA5A5, 5, 512, 2), 1'b1,
                     outcome(ST_READ_OOR, 0, 8, 0, 0, 0)});
    plan.push_back('{mk(CMD_CLEAR, 16'h5A5A, 2, 511, 61), 1'b1,
                     outcome(ST_CLEARED, 0, 0, 0, 0, 0)});
    plan.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1'b1, outcome(ST_READ_OOR, 0, 0, 0, 0, 0)});
    plan.push_back('{mk(CMD_ADD, 16'h8000, 6, 512, 0), 1'b1,
                     outcome(ST_INSERTED, 0, 1, 0, 0, 0)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[k]) offer(plan[k].it, plan[k].typed, plan[k].want);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 82 : 0;
      rcv_idle_pct <= (ph == 0) ? 82 : (ph == 1) ? 12 : 0;
      if (ph == 2) hold_reqs <= hold_reqs + 1;
      repeat (PHASE_ITEMS) offer(rand_item(), 1'b0, '0);
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results: kept %0d raised %0d inserted %0d replaced %0d",
             items_sent, results_seen, status_hits[ST_KEPT], status_hits[ST_RAISED],
             status_hits[ST_INSERTED], status_hits[ST_REPLACED]);
    $display("rejected %0d, reads %0d, out of range or ignored %0d, clears %0d",
             status_hits[ST_REJECTED], status_hits[ST_READ_OK], status_hits[ST_READ_OOR],
             status_hits[ST_CLEARED]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
